// ===== sv/glfa_pkg.sv =====
// Shared types, constants and the byte-to-log lookup for the gamma frame accumulator.
// No dependencies.
`timescale 1ns / 1ps

package glfa_pkg;

  localparam int PIXEL_COUNT_DEF = 2097152;
  localparam int ACC_BITS_DEF    = 24;
  localparam int IDX_W           = 21;
  localparam int CFG_W           = 17;
  localparam int CFG_AW          = 2;
  localparam int LOG_OFF         = 60801;  // Mitchell log offset, 2^20 units
  localparam int LW              = 27;     // signed log width
  localparam int PRW             = 40;     // signed log * exponent width

  localparam logic [11:0] GAMMA_RST     = 12'd563;
  localparam logic [10:0] INV_GAMMA_RST = 11'd116;
  localparam logic [16:0] WEIGHT_RST    = 17'd4096;

  typedef enum logic [CFG_AW-1:0] {
    REG_ONLY_FIRST = 2'd0,
    REG_GAMMA      = 2'd1,
    REG_INV_GAMMA  = 2'd2,
    REG_WEIGHT     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic        only_first;
    logic [11:0] gamma;
    logic [10:0] inv_gamma;
    logic [16:0] weight;
  } cfg_t;

  // Log of floor(x * 2^32 / 255) read as Q0.32, offset included
  function automatic logic signed [LW-1:0] lin_log(input logic [7:0] x);
    logic [32:0] q;
    logic [32:0] sq;
    logic [2:0]  pm;
    logic [6:0]  e_u;
    q  = 33'(x) * 33'h0_0101_0101 + 33'(x == 8'hFF);
    pm = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) pm = 3'(i);
    end
    sq  = q >> (4'(pm) + 4'd4);
    e_u = 7'(pm) - 7'd8;
    if (x == 8'hFF) begin
      return LW'(LOG_OFF);
    end
    return $signed({e_u, sq[19:0]}) + LW'(LOG_OFF);
  endfunction

endpackage

// ===== sv/glfa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read (old data on collision).
// No dependencies.
`timescale 1ns / 1ps

module glfa_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 2097152
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/glfa_lin.sv =====
// One colour channel: byte to weighted linear value, five register stages.
// Depends on glfa_pkg.
`timescale 1ns / 1ps

module glfa_lin #(
  parameter int ACC_BITS = glfa_pkg::ACC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic [7:0]           x_i,
  input  glfa_pkg::cfg_t       cfg_i,
  output logic [ACC_BITS-1:0]  w_o,
  output logic [ACC_BITS-1:0]  raw_o
);
  import glfa_pkg::*;

  localparam logic [ACC_BITS-1:0] FULL = {ACC_BITS{1'b1}};

  logic signed [LW-1:0]   l_q;
  logic signed [PRW-1:0]  prod_q;
  logic [ACC_BITS-1:0]    v_q, v_d;
  logic [ACC_BITS+16:0]   wp_q;
  logic [ACC_BITS-1:0]    w_q, w_d;
  logic                   z1_q, z2_q;
  logic [ACC_BITS-1:0]    raw_d, raw1_q, raw2_q, raw3_q, raw4_q, raw5_q;
  logic [32:0]            q;
  logic [32:0]            rq;
  logic signed [32:0]     t;
  logic [12:0]            sh;
  logic [ACC_BITS+20:0]   wide;

  // raw byte scaling: floor(x * 2^ACC_BITS / 255), clamped
  always_comb begin
    q  = 33'(x_i) * 33'h0_0101_0101 + 33'(x_i == 8'hFF);
    rq = q >> (32 - ACC_BITS);
    raw_d = (rq > 33'(FULL)) ? FULL : rq[ACC_BITS-1:0];
  end

  always_comb begin
    t    = 33'(prod_q >>> 8) - 33'(LOG_OFF);
    sh   = 13'd20 - t[32:20];
    wide = {1'b1, t[19:0], {ACC_BITS{1'b0}}} >> sh;
    if (z2_q) begin
      v_d = '0;
    end else if (!t[32]) begin
      v_d = FULL;
    end else begin
      v_d = wide[ACC_BITS-1:0];
    end
  end

  always_comb begin
    if (wp_q[ACC_BITS+16:16] > (ACC_BITS+1)'(FULL)) begin
      w_d = FULL;
    end else begin
      w_d = wp_q[ACC_BITS+15:16];
    end
  end

  always_ff @(posedge clk_i) begin
    l_q    <= lin_log(x_i);
    z1_q   <= (x_i == 8'd0);
    raw1_q <= raw_d;
    prod_q <= l_q * $signed({1'b0, cfg_i.gamma});
    z2_q   <= z1_q;
    raw2_q <= raw1_q;
    v_q    <= v_d;
    raw3_q <= raw2_q;
    wp_q   <= (ACC_BITS+17)'(v_q) * (ACC_BITS+17)'(cfg_i.weight);
    raw4_q <= raw3_q;
    w_q    <= w_d;
    raw5_q <= raw4_q;
  end

  assign w_o   = w_q;
  assign raw_o = raw5_q;

endmodule

// ===== sv/glfa_enc.sv =====
// One colour channel: stored linear value to gamma-encoded byte, four register stages.
// Depends on glfa_pkg.
`timescale 1ns / 1ps

module glfa_enc #(
  parameter int ACC_BITS = glfa_pkg::ACC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic [ACC_BITS-1:0] acc_i,
  input  glfa_pkg::cfg_t      cfg_i,
  output logic [7:0]          byte_o
);
  import glfa_pkg::*;

  localparam int PW = $clog2(ACC_BITS);

  logic [ACC_BITS-1:0]   acc_q;
  logic [PW-1:0]         p_d, p_q;
  logic                  z1_q, z2_q, z3_q;
  logic [7:0]            ofb_d, ofb1_q, ofb2_q, ofb3_q;
  logic [ACC_BITS+8:0]   ofb_t;
  logic [ACC_BITS+19:0]  norm;
  logic [6:0]            e_u;
  logic signed [LW-1:0]  l_q;
  logic signed [PRW-1:0] prod_q;
  logic signed [32:0]    t;
  logic [12:0]           sh;
  logic [28:0]           r;
  logic [7:0]            byte_d, byte_q;

  always_comb begin
    p_d = '0;
    for (int i = 0; i < ACC_BITS; i++) begin
      if (acc_i[i]) p_d = PW'(i);
    end
    // only-first readout: ((acc + 1) * 255) >> ACC_BITS, clamped
    ofb_t = ((ACC_BITS+9)'(acc_i) + (ACC_BITS+9)'(1)) * (ACC_BITS+9)'(255);
    ofb_d = (ofb_t[ACC_BITS+8:ACC_BITS] > 9'd255) ? 8'hFF : ofb_t[ACC_BITS+7:ACC_BITS];
  end

  always_comb begin
    norm = {acc_q, 20'd0} << (PW'(ACC_BITS - 1) - p_q);
    e_u  = 7'(p_q) - 7'(ACC_BITS);
  end

  always_comb begin
    t  = 33'(prod_q >>> 8) - 33'(LOG_OFF);
    sh = 13'd20 - t[32:20];
    r  = ({8'd0, 1'b1, t[19:0]} * 29'd255) >> sh;
    if (cfg_i.only_first) begin
      byte_d = ofb3_q;
    end else if (z3_q) begin
      byte_d = 8'd0;
    end else if (!t[32]) begin
      byte_d = 8'hFF;
    end else begin
      byte_d = r[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_i;
    p_q    <= p_d;
    z1_q   <= (acc_i == '0);
    ofb1_q <= ofb_d;
    l_q    <= $signed({e_u, norm[ACC_BITS+18 -: 20]}) + LW'(LOG_OFF);
    z2_q   <= z1_q;
    ofb2_q <= ofb1_q;
    prod_q <= l_q * $signed({2'b00, cfg_i.inv_gamma});
    z3_q   <= z2_q;
    ofb3_q <= ofb2_q;
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// ===== sv/gamma_linear_frame_accumulator_unit.sv =====
// Top level of the gamma frame accumulator: config registers, index wrap, store RMW, readout.
// Depends on glfa_pkg, glfa_ram, glfa_lin, glfa_enc.
//
//  channel  | ports                                             | handshake
//  ---------+---------------------------------------------------+-----------------------
//  command  | cmd, pixel_index, red/green/blue_in, end_of_frame | start_i & !busy_o
//  result   | out_index, red/green/blue/alpha_out, last_out     | valid_o, one cycle
//  config   | cfg_addr_i, cfg_wdata_i                           | cfg_we_i
//
// One command per clock, sustained; busy_o never rises.
// Readout results come out at the end of the command pipeline; accumulate commands give none.
// The store is one read-modify-write memory: read at stage 4, write at stage 5,
// with one-deep forwarding for back-to-back hits on the same pixel.
// Reset loads config defaults, clears frame-held and valid flags; store needs no clearing.
// The receiver cannot stall, so nothing inside ever waits.
`timescale 1ns / 1ps

module gamma_linear_frame_accumulator_unit #(
  parameter int PIXEL_COUNT = glfa_pkg::PIXEL_COUNT_DEF,
  parameter int ACC_BITS    = glfa_pkg::ACC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         cmd_i,
  input  logic [glfa_pkg::IDX_W-1:0]   pixel_index_i,
  input  logic [7:0]                   red_in_i,
  input  logic [7:0]                   green_in_i,
  input  logic [7:0]                   blue_in_i,
  input  logic                         end_of_frame_i,
  input  logic                         cfg_we_i,
  input  logic [glfa_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [glfa_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                         valid_o,
  output logic [glfa_pkg::IDX_W-1:0]   out_index_o,
  output logic [7:0]                   red_out_o,
  output logic [7:0]                   green_out_o,
  output logic [7:0]                   blue_out_o,
  output logic [7:0]                   alpha_out_o,
  output logic                         last_out_o
);
  import glfa_pkg::*;

  localparam int AW  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int RW  = (AW > IDX_W) ? AW : IDX_W;
  localparam int DW  = 3 * ACC_BITS;
  localparam int NST = 9;
  localparam longint RECIP = (64'(1) << IDX_W) / PIXEL_COUNT;
  localparam logic [RW:0] CNT = (RW+1)'(PIXEL_COUNT);
  localparam logic [ACC_BITS-1:0] FULL = {ACC_BITS{1'b1}};

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] idx;
    logic             eof;
    logic             wr;    // store is written
    logic             add;   // sum with stored value
    logic             raw;   // raw byte store
  } item_t;

  cfg_t  cfg_q;
  logic  filled_q;
  logic  accept;
  item_t item_d;
  item_t ctl_q [1:NST];
  logic [NST:1] vld_q;

  logic [IDX_W-1:0] q1_q;
  logic [RW-1:0]    r2_q, r3_q;
  logic [AW-1:0]    a4_q, a5_q;

  logic [DW-1:0] rdata, old_data, wdata;
  logic [DW-1:0] fwd_q;
  logic          hit_q;
  logic          we;

  logic [7:0]          bytes_in [3];
  logic [ACC_BITS-1:0] lin_w [3];
  logic [ACC_BITS-1:0] lin_raw [3];
  logic [7:0]          enc_b [3];

  assign accept = start_i & ~busy_o;
  assign busy_o = 1'b0;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.only_first <= 1'b0;
      cfg_q.gamma      <= GAMMA_RST;
      cfg_q.inv_gamma  <= INV_GAMMA_RST;
      cfg_q.weight     <= WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_addr_i))
        REG_ONLY_FIRST: cfg_q.only_first <= cfg_wdata_i[0];
        REG_GAMMA:      cfg_q.gamma      <= cfg_wdata_i[11:0];
        REG_INV_GAMMA:  cfg_q.inv_gamma  <= cfg_wdata_i[10:0];
        REG_WEIGHT:     cfg_q.weight     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // per-command decisions, taken against the frame-held flag as it stands at transfer
  always_comb begin
    item_d.cmd = cmd_i;
    item_d.idx = pixel_index_i;
    item_d.eof = end_of_frame_i;
    item_d.wr  = 1'b0;
    item_d.add = 1'b0;
    item_d.raw = 1'b0;
    if (!cmd_i) begin
      if (cfg_q.only_first) begin
        item_d.wr  = ~filled_q;
        item_d.raw = 1'b1;
      end else begin
        item_d.wr  = 1'b1;
        item_d.add = filled_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (accept && end_of_frame_i) begin
        filled_q <= ~cmd_i;
      end
      vld_q <= {vld_q[NST-1:1], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[1] <= item_d;
    for (int i = 2; i <= NST; i++) begin
      ctl_q[i] <= ctl_q[i-1];
    end
  end

  // index wrap: reciprocal estimate, then one correcting subtract
  always_ff @(posedge clk_i) begin
    q1_q <= IDX_W'(((2*IDX_W+2)'(pixel_index_i) * (2*IDX_W+2)'(RECIP)) >> IDX_W);
    r2_q <= RW'(RW'(ctl_q[1].idx) - RW'(q1_q * CNT));
    r3_q <= ((RW+1)'(r2_q) >= CNT) ? RW'((RW+1)'(r2_q) - CNT) : r2_q;
    a4_q <= r3_q[AW-1:0];
    a5_q <= a4_q;
  end

  assign bytes_in[0] = red_in_i;
  assign bytes_in[1] = green_in_i;
  assign bytes_in[2] = blue_in_i;

  for (genvar c = 0; c < 3; c++) begin : g_ch
    glfa_lin #(.ACC_BITS(ACC_BITS)) u_lin (
      .clk_i (clk_i),
      .x_i   (bytes_in[c]),
      .cfg_i (cfg_q),
      .w_o   (lin_w[c]),
      .raw_o (lin_raw[c])
    );

    glfa_enc #(.ACC_BITS(ACC_BITS)) u_enc (
      .clk_i  (clk_i),
      .acc_i  (old_data[c*ACC_BITS +: ACC_BITS]),
      .cfg_i  (cfg_q),
      .byte_o (enc_b[c])
    );
  end

  // stage 5: merge with stored value
  assign old_data = hit_q ? fwd_q : rdata;

  always_comb begin
    logic [ACC_BITS:0] sum;
    wdata = '0;
    for (int c = 0; c < 3; c++) begin
      sum = (ACC_BITS+1)'(lin_w[c]) + (ACC_BITS+1)'(old_data[c*ACC_BITS +: ACC_BITS]);
      if (ctl_q[5].raw) begin
        wdata[c*ACC_BITS +: ACC_BITS] = lin_raw[c];
      end else if (ctl_q[5].add) begin
        wdata[c*ACC_BITS +: ACC_BITS] = sum[ACC_BITS] ? FULL : sum[ACC_BITS-1:0];
      end else begin
        wdata[c*ACC_BITS +: ACC_BITS] = lin_w[c];
      end
    end
  end

  assign we = vld_q[5] & ctl_q[5].wr;

  // a read in stage 4 that meets the write in stage 5 takes the written data next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= vld_q[4] & we & (a4_q == a5_q);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= wdata;
  end

  glfa_ram #(.WIDTH(DW), .DEPTH(PIXEL_COUNT)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (a5_q),
    .wdata_i (wdata),
    .raddr_i (a4_q),
    .rdata_o (rdata)
  );

  assign valid_o     = vld_q[NST] & ctl_q[NST].cmd;
  assign out_index_o = ctl_q[NST].idx;
  assign last_out_o  = ctl_q[NST].eof;
  assign red_out_o   = enc_b[0];
  assign green_out_o = enc_b[1];
  assign blue_out_o  = enc_b[2];
  assign alpha_out_o = 8'hFF;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for gamma_linear_frame_accumulator_unit: directed table, then random
// frame sequences, checked against an in-bench gamma/linear-light predictor. Needs glfa_pkg.
`timescale 1ns / 1ps

module testbench;
  import glfa_pkg::*;

  localparam int           ACC      = 24;
  localparam longint       FRAC     = 64'd1048576;
  localparam longint       LOG_OFS  = 64'd60801;
  localparam longint unsigned FULL  = (64'd1 << ACC) - 1;
  localparam int           SETTLE   = 14;
  localparam int           WD_LIMIT = 4000;
  localparam bit           CMD_ACC  = 1'b0;
  localparam bit           CMD_RD   = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       alpha;
    logic             last;
  } pixel_res_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    reg_idx_e         addr;
    int unsigned      data;
    bit               cmd;
    logic [IDX_W-1:0] idx;
    logic [7:0]       r, g, b;
    bit               eof;
    bit               typed;
    logic [7:0]       er, eg, eb;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic             cmd_i = 1'b0;
  logic [IDX_W-1:0] pixel_index_i = '0;
  logic [7:0]       red_in_i = '0, green_in_i = '0, blue_in_i = '0;
  logic             end_of_frame_i = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_addr_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             valid_o;
  logic [IDX_W-1:0] out_index_o;
  logic [7:0]       red_out_o, green_out_o, blue_out_o, alpha_out_o;
  logic             last_out_o;

  gamma_linear_frame_accumulator_unit u_dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // predictor state
  cfg_t              cfg_m;
  bit [71:0]         lin_mem [int];
  logic [IDX_W-1:0]  written_q [$];
  bit                frame_held;
  pixel_res_t        pending_q [$];
  int                n_fail, n_items, n_reads, n_phases, idle_cnt;
  bit                calm;

  function automatic longint mitchell_log(longint unsigned v, int fb);
    int p;
    longint unsigned t, rem, m;
    p = 0;
    t = v;
    while (t > 1) begin
      t >>= 1;
      p++;
    end
    rem = v - (64'd1 << p);
    m = (p >= 20) ? (rem >> (p - 20)) : (rem << (20 - p));
    return longint'(p - fb) * FRAC + longint'(m) + LOG_OFS;
  endfunction

  function automatic void pow_split(input longint lg, input int unsigned g,
                                   output longint ex, output longint unsigned fr);
    longint t;
    t  = ((lg * longint'(g)) >>> 8) - LOG_OFS;
    ex = t >>> 20;
    fr = t & 64'hFFFFF;
  endfunction

  function automatic longint unsigned to_linear(logic [7:0] x);
    longint ex, s;
    longint unsigned fr, q, mant, v;
    if (x == 0) return 0;
    q = (longint'(x) << 32) / 255;
    pow_split(mitchell_log(q, 32), cfg_m.gamma, ex, fr);
    if (ex >= 0) return FULL;
    mant = FRAC + fr;
    s = ex + ACC - 20;
    if (s >= 0) v = mant << s;
    else v = (-s >= 40) ? 0 : (mant >> (-s));
    return (v > FULL) ? FULL : v;
  endfunction

  function automatic logic [7:0] to_gamma_byte(longint unsigned a);
    longint ex, sh;
    longint unsigned fr, r;
    if (a == 0) return 0;
    pow_split(mitchell_log(a, ACC), cfg_m.inv_gamma, ex, fr);
    if (ex >= 0) return 8'd255;
    sh = 20 - ex;
    r = (sh >= 63) ? 0 : (((FRAC + fr) * 255) >> sh);
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  // updates the store model; returns 1 with the pixel when a readout
  function automatic bit predict_pixel(bit cmd, logic [IDX_W-1:0] idx, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b, bit eof,
                                       output pixel_res_t res);
    logic [7:0]      ch [3];
    logic [7:0]      ob [3];
    bit [71:0]       ent;
    longint unsigned w, acc;
    ch = '{r, g, b};
    ent = lin_mem.exists(idx) ? lin_mem[idx] : '0;
    res = '0;
    if (cmd == CMD_ACC) begin
      if (!(cfg_m.only_first && frame_held)) begin
        for (int c = 0; c < 3; c++) begin
          if (cfg_m.only_first) begin
            w = (longint'(ch[c]) << ACC) / 255;
          end else begin
            w = (to_linear(ch[c]) * cfg_m.weight) >> 16;
            if (w > FULL) w = FULL;
            if (frame_held) w += ent[c*ACC +: ACC];
          end
          if (w > FULL) w = FULL;
          ent[c*ACC +: ACC] = w[ACC-1:0];
        end
        if (!lin_mem.exists(idx)) written_q = {written_q, idx};
        lin_mem[idx] = ent;
      end
      if (eof) frame_held = 1'b1;
      return 1'b0;
    end
    for (int c = 0; c < 3; c++) begin
      acc = ent[c*ACC +: ACC];
      if (cfg_m.only_first) begin
        w = ((acc + 1) * 255) >> ACC;
        ob[c] = (w > 255) ? 8'd255 : w[7:0];
      end else begin
        ob[c] = to_gamma_byte(acc);
      end
    end
    res = '{idx: idx, red: ob[0], green: ob[1], blue: ob[2], alpha: 8'd255, last: eof};
    if (eof) frame_held = 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // one command transfer; an untyped row takes the predictor's pixel
  task automatic send(bit cmd, logic [IDX_W-1:0] idx, logic [7:0] r, logic [7:0] g,
                      logic [7:0] b, bit eof, bit typed = 0, pixel_res_t want = '0);
    pixel_res_t res;
    int gap;
    start_i = 1'b1;
    cmd_i = cmd;
    pixel_index_i = idx;
    red_in_i = r;
    green_in_i = g;
    blue_in_i = b;
    end_of_frame_i = eof;
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    n_items++;
    if (predict_pixel(cmd, idx, r, g, b, eof, res)) begin
      n_reads++;
      pending_q = {pending_q, (typed ? want : res)};
    end
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start_i = 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic reg_write(reg_idx_e a, int unsigned d);
    cfg_we_i = 1'b1;
    cfg_addr_i = a;
    cfg_wdata_i = CFG_W'(d);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (a)
      REG_ONLY_FIRST: cfg_m.only_first = d[0];
      REG_GAMMA:      cfg_m.gamma = d[11:0];
      REG_INV_GAMMA:  cfg_m.inv_gamma = d[10:0];
      REG_WEIGHT:     cfg_m.weight = d[16:0];
      default: ;
    endcase
  endtask

  function automatic logic [IDX_W-1:0] stored_pixel();
    return written_q[$urandom_range(0, written_q.size() - 1)];
  endfunction

  function automatic logic [IDX_W-1:0] any_pixel();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return '1;
    return IDX_W'($urandom());
  endfunction

  function automatic logic [7:0] any_byte();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 8'd0;
    if (k == 1) return 8'd255;
    return 8'($urandom());
  endfunction

  task automatic chk(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // results are sampled at the edge that ends their cycle
  always @(posedge clk_i) begin
    pixel_res_t w;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer, index %0d", out_index_o);
        n_fail++;
      end else begin
        w = pending_q.pop_front();
        chk("out_index", w.idx, out_index_o);
        chk("red_out", w.red, red_out_o);
        chk("green_out", w.green, green_out_o);
        chk("blue_out", w.blue, blue_out_o);
        chk("alpha_out", w.alpha, alpha_out_o);
        chk("last_out", w.last, last_out_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || !rst_ni) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WD_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  row_t dir_rows [$];

  task automatic add_item(bit cmd, logic [IDX_W-1:0] idx, logic [7:0] r, logic [7:0] g,
                          logic [7:0] b, bit eof, bit typed = 0, logic [7:0] er = '0,
                          logic [7:0] eg = '0, logic [7:0] eb = '0);
    row_t w;
    w = '{kind: ROW_ITEM, addr: REG_ONLY_FIRST, data: 0, cmd: cmd, idx: idx, r: r, g: g,
          b: b, eof: eof, typed: typed, er: er, eg: eg, eb: eb};
    dir_rows = {dir_rows, w};
  endtask

  task automatic add_reg(reg_idx_e a, int unsigned d);
    row_t w;
    w = '{kind: ROW_REG, addr: a, data: d, cmd: 0, idx: 0, r: 0, g: 0, b: 0, eof: 0,
          typed: 0, er: 0, eg: 0, eb: 0};
    dir_rows = {dir_rows, w};
  endtask

  initial begin
    pixel_res_t want;
    logic [IDX_W-1:0] pix [8];
    int n_pix, n_frames, phase_start;
    bit cmd;
    logic [IDX_W-1:0] idx;

    cfg_m = '{only_first: 1'b0, gamma: GAMMA_RST, inv_gamma: INV_GAMMA_RST,
              weight: WEIGHT_RST};
    frame_held = 1'b0;
    n_fail = 0;
    n_items = 0;
    n_reads = 0;
    n_phases = 0;
    idle_cnt = 0;
    calm = 1'b0;

    // only-first round trip, ignored later frame, zero pixels, extremes of the registers
    add_reg(REG_ONLY_FIRST, 1);
    add_item(CMD_ACC, 0, 0, 255, 128, 0);
    add_item(CMD_ACC, 2097151, 255, 0, 1, 1);
    add_item(CMD_ACC, 0, 9, 9, 9, 1);
    add_item(CMD_RD, 0, 0, 0, 0, 0, 1, 0, 255, 128);
    add_item(CMD_RD, 2097151, 170, 85, 170, 1, 1, 255, 0, 1);
    add_reg(REG_ONLY_FIRST, 0);
    add_item(CMD_ACC, 0, 0, 0, 0, 0);
    add_item(CMD_ACC, 5, 255, 255, 255, 1);
    add_item(CMD_ACC, 5, 255, 255, 255, 1);
    add_item(CMD_ACC, 0, 0, 0, 0, 1);
    add_item(CMD_RD, 0, 255, 255, 255, 0, 1, 0, 0, 0);
    add_item(CMD_RD, 5, 0, 0, 0, 1);
    add_reg(REG_GAMMA, 64);
    add_reg(REG_INV_GAMMA, 1024);
    add_reg(REG_WEIGHT, 65536);
    add_item(CMD_ACC, 7, 1, 128, 255, 1);
    add_item(CMD_ACC, 7, 254, 2, 127, 1);
    add_item(CMD_RD, 7, 0, 0, 0, 1);
    add_reg(REG_GAMMA, 2048);
    add_reg(REG_INV_GAMMA, 32);
    add_reg(REG_WEIGHT, 1);
    add_item(CMD_ACC, 9, 1, 128, 255, 0);
    add_item(CMD_ACC, 9, 255, 64, 3, 1);
    add_item(CMD_RD, 9, 0, 0, 0, 1);

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        drain();
        reg_write(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        want = '{idx: dir_rows[i].idx, red: dir_rows[i].er, green: dir_rows[i].eg,
                 blue: dir_rows[i].eb, alpha: 8'd255, last: dir_rows[i].eof};
        send(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].r, dir_rows[i].g,
             dir_rows[i].b, dir_rows[i].eof, dir_rows[i].typed, want);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      n_phases++;
      reg_write(REG_ONLY_FIRST, $urandom_range(0, 4) == 0);
      reg_write(REG_GAMMA, (ph == 0) ? 64 : (ph == 1) ? 2048 : $urandom_range(64, 2048));
      reg_write(REG_INV_GAMMA, (ph == 0) ? 1024 : (ph == 1) ? 32 : $urandom_range(32, 1024));
      reg_write(REG_WEIGHT, (ph == 2) ? 1 : (ph == 3) ? 65536 : $urandom_range(1, 65536));
      calm = ($urandom_range(0, 3) == 0);
      phase_start = n_items;
      while (n_items - phase_start < 140) begin
        if ($urandom_range(0, 99) < 80) begin
          // clear a held frame so the first frame below overwrites fresh pixels
          if (frame_held) send(CMD_RD, stored_pixel(), any_byte(), any_byte(), any_byte(), 1);
          n_pix = $urandom_range(1, 8);
          n_frames = $urandom_range(1, 4);
          for (int i = 0; i < n_pix; i++)
            pix[i] = ($urandom_range(0, 3) == 0 && i > 0) ? pix[i-1] : any_pixel();
          for (int f = 0; f < n_frames; f++)
            for (int i = 0; i < n_pix; i++)
              send(CMD_ACC, pix[i], any_byte(), any_byte(), any_byte(), i == n_pix - 1);
          for (int i = 0; i < n_pix; i++)
            send(CMD_RD, pix[i], any_byte(), any_byte(), any_byte(), i == n_pix - 1);
        end else begin
          cmd = 1'($urandom_range(0, 1));
          if (written_q.size() == 0) cmd = CMD_ACC;
          if (cmd == CMD_RD || (frame_held && !cfg_m.only_first)) idx = stored_pixel();
          else idx = any_pixel();
          send(cmd, idx, any_byte(), any_byte(), any_byte(), 1'($urandom_range(0, 1)));
        end
      end
    end

    drain();
    $display("Covered %0d command transfers, %0d readouts, %0d register phases.",
             n_items, n_reads, n_phases);
    if (n_fail == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
